>>> sv/gcd_lcm_unit_defines.svh
// assertion macros for the gcd / lcm unit
// no dependencies; taken in by the modules that carry assertions
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GLU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/glu_pkg.sv
// shared constants, datapath command codes and status type for the gcd / lcm unit
// no dependencies
package glu_pkg;

    // operand and result widths
    localparam int OP_W      = 55;
    localparam int RES_W     = 64;
    localparam int LIMIT_LOG = 53;

    // working width: an in-range magnitude (at most 2^53) fits here
    localparam int DP_W  = (OP_W < LIMIT_LOG + 1) ? OP_W : LIMIT_LOG + 1;
    localparam int CNT_W = $clog2(DP_W + 1);

    // largest accepted magnitude
    localparam logic [RES_W-1:0] MAG_LIMIT = RES_W'(1) << LIMIT_LOG;

    // datapath commands
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_NONE     = 3'd0;
    localparam t_cmd CMD_LOAD     = 3'd1;
    localparam t_cmd CMD_GCD      = 3'd2;
    localparam t_cmd CMD_SCALE    = 3'd3;
    localparam t_cmd CMD_DIV_INIT = 3'd4;
    localparam t_cmd CMD_DIV      = 3'd5;
    localparam t_cmd CMD_MUL      = 3'd6;
    localparam t_cmd CMD_FINISH   = 3'd7;

    // datapath status seen by the controller
    typedef struct packed {
        logic range_err;  // an operand magnitude is above the limit
        logic op_lcm;     // request asks for the lcm
        logic zero_any;   // an operand magnitude is zero
        logic gcd_fin;    // reduction loop has converged
        logic k_zero;     // no common factors of two left to restore
        logic cnt_last;   // divide / multiply bit counter on its last step
        logic cnt_zero;   // divide / multiply bit counter exhausted
    } t_status;

endpackage

>>> sv/glu_datapath.sv
// datapath of the gcd / lcm unit: binary gcd, restoring divider, serial multiplier
// depends on glu_pkg; driven by glu_ctrl through command and status
module glu_datapath (
    input  logic                            i_clk,
    input  glu_pkg::t_cmd                   i_cmd,
    input  logic                            i_req_type,
    input  logic signed [glu_pkg::OP_W-1:0] i_operand_a,
    input  logic signed [glu_pkg::OP_W-1:0] i_operand_b,
    output glu_pkg::t_status                o_sts,
    output logic [glu_pkg::RES_W-1:0]       o_result,
    output logic                            o_overflow,
    output logic                            o_range_error
);

    // operand magnitudes
    logic [glu_pkg::OP_W-1:0] a_u, b_u, mag_a, mag_b;
    logic                     rerr_in;

    // working registers
    logic [glu_pkg::DP_W-1:0]  r_ma, r_mb, r_x, r_y, r_rem;
    logic [glu_pkg::CNT_W-1:0] r_k, r_cnt;
    logic [glu_pkg::RES_W-1:0] r_acc;
    logic                      r_ovf, r_op, r_rerr;
    logic [glu_pkg::RES_W-1:0] r_result;
    logic                      r_overflow, r_range_error;

    // step results
    logic [glu_pkg::DP_W:0]    rem_sh, diff;
    logic                      qbit;
    logic [glu_pkg::RES_W+1:0] mac;
    logic [glu_pkg::DP_W-1:0]  x_minus_y, y_minus_x;

    // two's complement magnitudes, most negative value formed exactly
    assign a_u   = i_operand_a;
    assign b_u   = i_operand_b;
    assign mag_a = a_u[glu_pkg::OP_W-1] ? (~a_u) + glu_pkg::OP_W'(1) : a_u;
    assign mag_b = b_u[glu_pkg::OP_W-1] ? (~b_u) + glu_pkg::OP_W'(1) : b_u;
    assign rerr_in = (glu_pkg::RES_W'(mag_a) > glu_pkg::MAG_LIMIT)
                   | (glu_pkg::RES_W'(mag_b) > glu_pkg::MAG_LIMIT);

    // divider step: shift in next dividend bit, trial subtract
    assign rem_sh = {r_rem, r_x[glu_pkg::DP_W-1]};
    assign diff   = rem_sh - {1'b0, r_y};
    assign qbit   = ~diff[glu_pkg::DP_W];

    // multiplier step, msb first: acc = 2*acc + bit*mb
    assign mac = {1'b0, r_acc, 1'b0}
               + (r_x[glu_pkg::DP_W-1] ? (glu_pkg::RES_W+2)'(r_mb) : '0);

    assign x_minus_y = r_x - r_y;
    assign y_minus_x = r_y - r_x;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            glu_pkg::CMD_LOAD: begin
                r_ma   <= mag_a[glu_pkg::DP_W-1:0];
                r_mb   <= mag_b[glu_pkg::DP_W-1:0];
                r_x    <= mag_a[glu_pkg::DP_W-1:0];
                r_y    <= mag_b[glu_pkg::DP_W-1:0];
                r_k    <= '0;
                r_op   <= i_req_type;
                r_rerr <= rerr_in;
            end
            glu_pkg::CMD_GCD: begin
                if (r_x == '0) begin
                    r_x <= r_y;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= x_minus_y;
                end else begin
                    r_y <= y_minus_x;
                end
            end
            glu_pkg::CMD_SCALE: begin
                r_x <= r_x << 1;
                r_k <= r_k - 1'b1;
            end
            glu_pkg::CMD_DIV_INIT: begin
                r_y   <= r_x;
                r_x   <= r_ma;
                r_rem <= '0;
                r_cnt <= glu_pkg::CNT_W'(glu_pkg::DP_W);
            end
            glu_pkg::CMD_DIV: begin
                r_rem <= qbit ? diff[glu_pkg::DP_W-1:0] : rem_sh[glu_pkg::DP_W-1:0];
                r_x   <= {r_x[glu_pkg::DP_W-2:0], qbit};
                // multiplier starts clean once the quotient is complete
                r_acc <= '0;
                r_ovf <= 1'b0;
                // last step rearms the counter for the multiply
                if (r_cnt == glu_pkg::CNT_W'(1)) begin
                    r_cnt <= glu_pkg::CNT_W'(glu_pkg::DP_W);
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            glu_pkg::CMD_MUL: begin
                r_acc <= mac[glu_pkg::RES_W-1:0];
                r_ovf <= r_ovf | (|mac[glu_pkg::RES_W+1:glu_pkg::RES_W]);
                r_x   <= r_x << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            glu_pkg::CMD_FINISH: begin
                r_range_error <= r_rerr;
                if (r_rerr) begin
                    r_result   <= '0;
                    r_overflow <= 1'b0;
                end else if (!r_op) begin
                    r_result   <= glu_pkg::RES_W'(r_x);
                    r_overflow <= 1'b0;
                end else if ((r_ma == '0) || (r_mb == '0)) begin
                    r_result   <= '0;
                    r_overflow <= 1'b0;
                end else if (r_ovf) begin
                    r_result   <= '1;
                    r_overflow <= 1'b1;
                end else begin
                    r_result   <= r_acc;
                    r_overflow <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // status back to the controller
    assign o_sts.range_err = r_rerr;
    assign o_sts.op_lcm    = r_op;
    assign o_sts.zero_any  = (r_ma == '0) || (r_mb == '0);
    assign o_sts.gcd_fin   = (r_x == r_y) || (r_y == '0);
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.cnt_last  = (r_cnt == glu_pkg::CNT_W'(1));
    assign o_sts.cnt_zero  = (r_cnt == '0);

    assign o_result      = r_result;
    assign o_overflow    = r_overflow;
    assign o_range_error = r_range_error;

endmodule

>>> sv/glu_ctrl.sv
// controller of the gcd / lcm unit: sequences the datapath one step per cycle
// depends on glu_pkg and gcd_lcm_unit_defines.svh
`include "gcd_lcm_unit_defines.svh"

module glu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  glu_pkg::t_status i_sts,
    output glu_pkg::t_cmd    o_cmd,
    output logic             o_strobe
);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GCD   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_strobe, n_strobe;

    // next state and command
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = glu_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd   = glu_pkg::CMD_LOAD;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.range_err) begin
                    n_state = S_FIN;
                end else if (i_sts.gcd_fin) begin
                    n_state = S_SCALE;
                end else begin
                    o_cmd = glu_pkg::CMD_GCD;
                end
            end
            S_SCALE: begin
                if (!i_sts.k_zero) begin
                    o_cmd = glu_pkg::CMD_SCALE;
                end else if (i_sts.op_lcm && !i_sts.zero_any) begin
                    o_cmd   = glu_pkg::CMD_DIV_INIT;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                // last divide step also rearms the counter for the multiply
                o_cmd = glu_pkg::CMD_DIV;
                if (i_sts.cnt_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd = glu_pkg::CMD_MUL;
                end
            end
            S_FIN: begin
                o_cmd    = glu_pkg::CMD_FINISH;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    // checks
    `GLU_ASSERT_NEXT(a_fin_strobes, r_state == S_FIN, r_strobe && r_state == S_IDLE, "no word after finish")
    `GLU_ASSERT_NOW(a_strobe_from_fin, r_strobe, $past(r_state) == S_FIN, "word without finish step")
    `GLU_ASSERT_NEXT(a_start_loads, start && r_state == S_IDLE, r_state == S_GCD, "accepted word not loaded")
    `GLU_ASSERT_NOW(a_lcm_only, r_state == S_DIV || r_state == S_MUL, i_sts.op_lcm && !i_sts.range_err, "divide or multiply outside lcm")

endmodule

>>> sv/gcd_lcm_unit.sv
// top level of the gcd / lcm unit
// depends on glu_pkg, glu_ctrl and glu_datapath
//
// Takes a request (start high while busy is low) with an operation and two signed
// operands, and returns the gcd or lcm of their magnitudes as one word on o_result,
// o_overflow and o_range_error, valid for exactly the single cycle that o_strobe is
// high; the receiver cannot hold it off, so it must capture the word that cycle.
// One request is in progress at a time; busy stays high from acceptance until the
// strobe. The gcd runs as a binary (shift and subtract) loop, one step per cycle,
// then doubles the result once for each common factor of two that the operands shared.
// An lcm then adds a restoring divide and a shift-add multiply, one bit per cycle each
// over 54 bits. A range error skips the loop and goes straight to the finish step.
module gcd_lcm_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_req_type,
    input  logic signed [glu_pkg::OP_W-1:0] i_operand_a,
    input  logic signed [glu_pkg::OP_W-1:0] i_operand_b,
    output logic                            o_strobe,
    output logic [glu_pkg::RES_W-1:0]       o_result,
    output logic                            o_overflow,
    output logic                            o_range_error
);

    glu_pkg::t_cmd    cmd;
    glu_pkg::t_status sts;

    // sequencer
    glu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_strobe (o_strobe)
    );

    // arithmetic
    glu_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_sts         (sts),
        .o_result      (o_result),
        .o_overflow    (o_overflow),
        .o_range_error (o_range_error)
    );

endmodule

>>> verif/gcd_lcm_unit_test.sv
// self-checking testbench for the gcd / lcm unit: directed corner words, then random bursts
// depends on glu_pkg and the gcd_lcm_unit rtl; results are predicted by a scoreboard class
`timescale 1ns / 100ps

module gcd_lcm_unit_test;

    // widths and limit taken from the package
    localparam int               OP_W      = glu_pkg::OP_W;
    localparam int               RES_W     = glu_pkg::RES_W;
    localparam int               LIMIT_LOG = glu_pkg::LIMIT_LOG;
    localparam logic [RES_W-1:0] MAG_LIMIT = glu_pkg::MAG_LIMIT;

    // request operations
    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

    localparam int unsigned RANDOM_WORDS = 1450;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned MAX_REPORTS  = 10;

    // one request together with the word it should produce
    typedef struct {
        logic                    op;
        logic signed [OP_W-1:0]  a;
        logic signed [OP_W-1:0]  b;
        logic [RES_W-1:0]        result;
        logic                    overflow;
        logic                    range_error;
    } t_gcd_lcm_due;

    // predicts each accepted request and checks the words in order
    class gcd_lcm_ledger;
        t_gcd_lcm_due due_q[$];
        int unsigned  words_checked = 0;
        int unsigned  mismatches    = 0;
        int unsigned  n_gcd = 0, n_lcm = 0, n_range = 0, n_sat = 0, n_zero = 0;

        // magnitude of a two's complement operand, exact for the most negative value
        function logic [RES_W-1:0] magnitude(logic signed [OP_W-1:0] v);
            logic [RES_W-1:0] ext;
            ext = {{(RES_W-OP_W){v[OP_W-1]}}, v};
            return v[OP_W-1] ? (~ext + 1'b1) : ext;
        endfunction

        // euclid remainder loop
        function logic [RES_W-1:0] euclid(logic [RES_W-1:0] x, logic [RES_W-1:0] y);
            logic [RES_W-1:0] r;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_request(logic op, logic signed [OP_W-1:0] a,
                                   logic signed [OP_W-1:0] b);
            t_gcd_lcm_due     d;
            logic [RES_W-1:0] ma, mb, g, q;
            logic [2*RES_W-1:0] prod;
            d.op = op;
            d.a = a;
            d.b = b;
            d.result = '0;
            d.overflow = 1'b0;
            d.range_error = 1'b0;
            ma = magnitude(a);
            mb = magnitude(b);
            if (op == OP_GCD) n_gcd++; else n_lcm++;
            if (ma > MAG_LIMIT || mb > MAG_LIMIT) begin
                d.range_error = 1'b1;
                n_range++;
            end else if (op == OP_GCD) begin
                d.result = euclid(ma, mb);
                if (ma == 0 || mb == 0) n_zero++;
            end else if (ma == 0 || mb == 0) begin
                // lcm with a zero operand gives zero
                n_zero++;
            end else begin
                g = euclid(ma, mb);
                q = ma / g;
                prod = {{RES_W{1'b0}}, q} * {{RES_W{1'b0}}, mb};
                if (prod[2*RES_W-1:RES_W] != 0) begin
                    d.result = '1;
                    d.overflow = 1'b1;
                    n_sat++;
                end else begin
                    d.result = prod[RES_W-1:0];
                end
            end
            due_q.push_back(d);
        endfunction

        function void report_field(string field, logic [RES_W-1:0] want,
                                   logic [RES_W-1:0] got, t_gcd_lcm_due d);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: op %0b a %0d b %0d, expected %0d, got %0d",
                         field, d.op, d.a, d.b, want, got);
        endfunction

        function void check_word(logic [RES_W-1:0] result, logic overflow,
                                 logic range_error);
            t_gcd_lcm_due d;
            words_checked++;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: result %0d overflow %0b range_error %0b",
                             result, overflow, range_error);
                return;
            end
            d = due_q.pop_front();
            if (result !== d.result)
                report_field("result", d.result, result, d);
            if (overflow !== d.overflow)
                report_field("overflow", d.overflow, overflow, d);
            if (range_error !== d.range_error)
                report_field("range_error", d.range_error, range_error, d);
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_req_type;
    logic signed [OP_W-1:0] i_operand_a;
    logic signed [OP_W-1:0] i_operand_b;
    logic                   o_strobe;
    logic [RES_W-1:0]       o_result;
    logic                   o_overflow;
    logic                   o_range_error;

    gcd_lcm_ledger ledger = new();
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;

    gcd_lcm_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .o_overflow    (o_overflow),
        .o_range_error (o_range_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, ledger.pending());
            $display("[gcd_lcm_unit] ERROR");
            $finish;
        end
    end

    // result words are taken on the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            ledger.check_word(o_result, o_overflow, o_range_error);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random in-range magnitude of random width, sometimes at or just below the limit
    function automatic logic [63:0] pick_magnitude(int unsigned max_w);
        int unsigned w;
        w = $urandom_range(1, max_w);
        if ($urandom_range(0, 15) == 0 && max_w == LIMIT_LOG)
            return MAG_LIMIT - 64'($urandom_range(0, 2));
        return rand64() & ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic signed [OP_W-1:0] with_sign(logic [63:0] mag);
        logic [OP_W-1:0] v;
        v = mag[OP_W-1:0];
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // idle the request fields with noise while start is low
    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
            i_req_type = 1'($urandom_range(0, 1));
            i_operand_a = OP_W'(rand64());
            i_operand_b = OP_W'(rand64());
        end
    endtask

    // offer one request and hold start high while busy is high, then pace the next one
    task automatic send_request(logic op, logic signed [OP_W-1:0] a,
                                logic signed [OP_W-1:0] b);
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = op;
        i_operand_a = a;
        i_operand_b = b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.note_request(op, a, b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(20, 250));
            else
                idle_cycles($urandom_range(1, 8));
        end
    endtask

    // corner words: zeros, signs, range limit, saturation edge, long euclid chains
    task automatic run_directed();
        send_request(OP_GCD, 55'sd0, 55'sd0);
        send_request(OP_GCD, 55'sd0, -55'sd7);
        send_request(OP_GCD, 55'sd12, 55'sd0);
        send_request(OP_LCM, 55'sd0, 55'sd0);
        send_request(OP_LCM, 55'sd0, 55'sd5);
        send_request(OP_LCM, -55'sd9, 55'sd0);
        send_request(OP_GCD, -55'sd12, 55'sd18);
        send_request(OP_LCM, -55'sd4, -55'sd6);
        send_request(OP_GCD, 55'sd9007199254740992, -55'sd9007199254740992);
        send_request(OP_LCM, 55'sd9007199254740992, 55'sd9007199254740992);
        send_request(OP_GCD, 55'sd9007199254740993, 55'sd5);
        send_request(OP_LCM, 55'sd3, -55'sd9007199254740993);
        send_request(OP_GCD, {1'b1, {(OP_W-1){1'b0}}}, 55'sd3);
        send_request(OP_LCM, 55'sd18014398509481983, 55'sd1);
        send_request(OP_LCM, 55'sd9007199254740991, 55'sd9007199254740989);
        send_request(OP_LCM, 55'sd4294967295, 55'sd4294967297);
        send_request(OP_LCM, 55'sd4294967297, 55'sd4294967299);
        send_request(OP_GCD, 55'sd8944394323791464, 55'sd5527939700884757);
        send_request(OP_LCM, 55'sd5527939700884757, -55'sd8944394323791464);
        send_request(OP_GCD, 55'sd3298534883328, 55'sd9437184);
        send_request(OP_GCD, 55'sd1, 55'sd9007199254740992);
        send_request(OP_GCD, -55'sd7777, -55'sd7777);
    endtask

    // random pairs: mostly in range, some with shared factors, zeros and out of range
    task automatic run_random();
        int unsigned      kind, wg;
        logic [63:0]      g;
        logic signed [OP_W-1:0] a, b;
        repeat (RANDOM_WORDS) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                a = OP_W'(rand64());
                b = OP_W'(rand64());
            end else if (kind == 2) begin
                a = with_sign(MAG_LIMIT + 64'($urandom_range(1, 3)));
                b = with_sign(pick_magnitude(LIMIT_LOG));
                if ($urandom_range(0, 1)) begin
                    b = a;
                    a = with_sign(pick_magnitude(LIMIT_LOG));
                end
            end else if (kind == 3) begin
                a = $urandom_range(0, 1) ? '0 : with_sign(pick_magnitude(LIMIT_LOG));
                b = (a == 0 && $urandom_range(0, 2) != 0) ?
                    with_sign(pick_magnitude(LIMIT_LOG)) : '0;
            end else if (kind < 9) begin
                wg = $urandom_range(1, 26);
                g = pick_magnitude(wg) | 64'd1;
                a = with_sign(g * pick_magnitude(LIMIT_LOG - wg));
                b = with_sign(g * pick_magnitude(LIMIT_LOG - wg));
            end else if (kind < 12) begin
                a = with_sign(64'($urandom_range(0, 1000)));
                b = with_sign(64'($urandom_range(0, 1000)));
            end else begin
                a = with_sign(pick_magnitude(LIMIT_LOG));
                b = with_sign(pick_magnitude(LIMIT_LOG));
            end
            send_request(1'($urandom_range(0, 1)), a, b);
        end
    endtask

    // reset, stimulus, drain and verdict
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = OP_GCD;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_cycles(3);

        run_directed();
        run_random();
        idle_cycles(1);

        // drain the outstanding words
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d gcd and %0d lcm requests: %0d range errors, %0d saturated lcms,",
                 ledger.n_gcd, ledger.n_lcm, ledger.n_range, ledger.n_sat);
        $display("%0d with a zero operand; %0d words checked, %0d mismatches",
                 ledger.n_zero, ledger.words_checked, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("[gcd_lcm_unit] OK");
        end else begin
            $display("[gcd_lcm_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> gcd_lcm_unit.f
+incdir+sv
sv/glu_pkg.sv
sv/glu_datapath.sv
sv/glu_ctrl.sv
sv/gcd_lcm_unit.sv
verif/gcd_lcm_unit_test.sv
